// ===== hw/rtl/strmm_pkg.sv =====
// ----------------------------------------------------------------------------
// strmm_pkg
// Shared types and codes for the sparse table range min/max unit.
// ----------------------------------------------------------------------------
package strmm_pkg;

  // Width of the range index fields on the request channel.
  localparam int RNG_W = 10;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // Commands passed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_APPEND,
    OP_QUERY,
    OP_BAD
  } op_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND,
    ST_QDATA
  } st_t;

endpackage

// ===== hw/rtl/strmm_if.sv =====
// ----------------------------------------------------------------------------
// strmm_if
// Valid/ready channels for the request and result sides of the unit.
// ----------------------------------------------------------------------------
interface strmm_req_if #(
  parameter int VALUE_BITS = 32
);
  logic                             valid;
  logic                             ready;
  logic [1:0]                       req_type;
  logic signed [VALUE_BITS-1:0]     value;
  logic [strmm_pkg::RNG_W-1:0]      range_low;
  logic [strmm_pkg::RNG_W-1:0]      range_high;

  modport source (output valid, req_type, value, range_low, range_high, input ready);
  modport sink (input valid, req_type, value, range_low, range_high, output ready);
endinterface

interface strmm_res_if #(
  parameter int VALUE_BITS = 32
);
  logic                             valid;
  logic                             ready;
  logic signed [VALUE_BITS-1:0]     range_max;
  logic signed [VALUE_BITS-1:0]     range_min;
  logic                             bad_range;

  modport source (output valid, range_max, range_min, bad_range, input ready);
  modport sink (input valid, range_max, range_min, bad_range, output ready);
endinterface

// ===== hw/rtl/strmm_front.sv =====
// ----------------------------------------------------------------------------
// strmm_front
// Takes requests, counts elements and turns each query and each append with
// room into a ready-to-run command: table index, level and range check done.
// ----------------------------------------------------------------------------
module strmm_front #(
  parameter int MAX_ELEMS  = 1024,
  parameter int LEVELS     = 11,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  strmm_req_if.sink                    req,
  output logic                         push,
  input  logic                         push_ready,
  output strmm_pkg::op_t               op,
  output logic signed [VALUE_BITS-1:0] val,
  output logic [$clog2(MAX_ELEMS)-1:0] idx_a,
  output logic [$clog2(MAX_ELEMS)-1:0] idx_b,
  output logic [$clog2(LEVELS)-1:0]    lvl
);

  localparam int IDX_W = $clog2(MAX_ELEMS);
  localparam int CNT_W = $clog2(MAX_ELEMS + 1);
  localparam int LVL_W = $clog2(LEVELS);
  localparam int CMP_W = ((CNT_W > strmm_pkg::RNG_W) ? CNT_W : strmm_pkg::RNG_W) + 1;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             accept;
  logic             full;
  logic [CNT_W-1:0] cnt_p1;
  logic [LVL_W-1:0] app_lvl;
  logic [CMP_W-1:0] lo_x;
  logic [CMP_W-1:0] hi_x;
  logic [CMP_W-1:0] cnt_x;
  logic [CMP_W-1:0] len;
  logic [CMP_W-1:0] j2;
  logic [LVL_W-1:0] q_lvl;
  logic             bad;

  assign req.ready = push_ready;
  assign accept    = req.valid && push_ready;
  assign full      = (cnt == CNT_W'(MAX_ELEMS));
  assign cnt_p1    = cnt + CNT_W'(1);

  // top level filled by an append: floor(log2(count+1)), capped
  always_comb begin
    app_lvl = '0;
    for (int k = 1; k < LEVELS; k++) begin
      if ((cnt_p1 >> k) != '0) begin
        app_lvl = LVL_W'(k);
      end
    end
  end

  // query check, block level and start of the right-hand block
  assign lo_x  = CMP_W'(req.range_low);
  assign hi_x  = CMP_W'(req.range_high);
  assign cnt_x = CMP_W'(cnt);
  assign bad   = (cnt == '0) || (lo_x > hi_x) || (hi_x >= cnt_x);
  assign len   = hi_x - lo_x + CMP_W'(1);

  always_comb begin
    q_lvl = '0;
    for (int k = 1; k < LEVELS; k++) begin
      if ((len >> k) != '0) begin
        q_lvl = LVL_W'(k);
      end
    end
  end

  assign j2 = hi_x + CMP_W'(1) - (CMP_W'(1) << q_lvl);

  always_comb begin
    push     = 1'b0;
    op       = strmm_pkg::OP_BAD;
    val      = req.value;
    idx_a    = IDX_W'(lo_x);
    idx_b    = IDX_W'(j2);
    lvl      = q_lvl;
    cnt_next = cnt;
    case (req.req_type)
      strmm_pkg::REQ_CLEAR: begin
        cnt_next = '0;
      end
      strmm_pkg::REQ_APPEND: begin
        if (!full) begin
          push     = accept;
          op       = strmm_pkg::OP_APPEND;
          idx_a    = IDX_W'(cnt);
          lvl      = app_lvl;
          cnt_next = cnt_p1;
        end
      end
      strmm_pkg::REQ_QUERY: begin
        push = accept;
        op   = bad ? strmm_pkg::OP_BAD : strmm_pkg::OP_QUERY;
      end
      default: begin
        cnt_next = cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= cnt_next;
    end
  end

endmodule

// ===== hw/rtl/strmm_queue.sv =====
// ----------------------------------------------------------------------------
// strmm_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module strmm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hw/rtl/strmm_back.sv =====
// ----------------------------------------------------------------------------
// strmm_back
// Runs commands against the max/min sparse tables and drives the result
// register. Appends sweep the levels one a cycle; queries read two entries.
// ----------------------------------------------------------------------------
module strmm_back #(
  parameter int MAX_ELEMS  = 1024,
  parameter int LEVELS     = 11,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  strmm_pkg::op_t               q_op,
  input  logic signed [VALUE_BITS-1:0] q_val,
  input  logic [$clog2(MAX_ELEMS)-1:0] q_idx_a,
  input  logic [$clog2(MAX_ELEMS)-1:0] q_idx_b,
  input  logic [$clog2(LEVELS)-1:0]    q_lvl,
  strmm_res_if.source                  res
);

  localparam int IDX_W     = $clog2(MAX_ELEMS);
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int ADDR_W    = LVL_W + IDX_W;
  localparam int MEM_DEPTH = LEVELS * (2 ** IDX_W);

  logic signed [VALUE_BITS-1:0] max_mem [MEM_DEPTH];
  logic signed [VALUE_BITS-1:0] min_mem [MEM_DEPTH];

  strmm_pkg::st_t state;
  strmm_pkg::st_t state_next;

  logic [LVL_W-1:0]             k;
  logic [LVL_W-1:0]             top;
  logic [IDX_W-1:0]             j;
  logic [IDX_W-1:0]             step;
  logic signed [VALUE_BITS-1:0] cur_max;
  logic signed [VALUE_BITS-1:0] cur_min;
  logic signed [VALUE_BITS-1:0] rd_a_max;
  logic signed [VALUE_BITS-1:0] rd_b_max;
  logic signed [VALUE_BITS-1:0] rd_a_min;
  logic signed [VALUE_BITS-1:0] rd_b_min;

  logic                         out_free;
  logic                         wr_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic signed [VALUE_BITS-1:0] wr_max;
  logic signed [VALUE_BITS-1:0] wr_min;
  logic [ADDR_W-1:0]            rd_addr_a;
  logic [ADDR_W-1:0]            rd_addr_b;
  logic                         load_out;
  logic signed [VALUE_BITS-1:0] new_max;
  logic signed [VALUE_BITS-1:0] new_min;
  logic                         new_bad;
  logic signed [VALUE_BITS-1:0] app_max;
  logic signed [VALUE_BITS-1:0] app_min;

  assign out_free = !res.valid || res.ready;

  // level k entry = combine(level k-1 at j, previous level's result)
  assign app_max = (rd_a_max > cur_max) ? rd_a_max : cur_max;
  assign app_min = (rd_a_min < cur_min) ? rd_a_min : cur_min;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      strmm_pkg::ST_IDLE: begin
        if (q_pop && q_op == strmm_pkg::OP_APPEND && q_lvl != '0) begin
          state_next = strmm_pkg::ST_APPEND;
        end else if (q_pop && q_op == strmm_pkg::OP_QUERY) begin
          state_next = strmm_pkg::ST_QDATA;
        end
      end
      strmm_pkg::ST_APPEND: begin
        if (k == top) begin
          state_next = strmm_pkg::ST_IDLE;
        end
      end
      strmm_pkg::ST_QDATA: begin
        state_next = strmm_pkg::ST_IDLE;
      end
      default: begin
        state_next = strmm_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = {k, j};
    wr_max    = app_max;
    wr_min    = app_min;
    rd_addr_a = {k, j - step};
    rd_addr_b = {q_lvl, q_idx_b};
    load_out  = 1'b0;
    new_max   = (rd_a_max > rd_b_max) ? rd_a_max : rd_b_max;
    new_min   = (rd_a_min < rd_b_min) ? rd_a_min : rd_b_min;
    new_bad   = 1'b0;
    case (state)
      strmm_pkg::ST_IDLE: begin
        if (q_valid && (q_op == strmm_pkg::OP_APPEND || out_free)) begin
          q_pop = 1'b1;
        end
        case (q_op)
          strmm_pkg::OP_APPEND: begin
            wr_en     = q_pop;
            wr_addr   = {LVL_W'(0), q_idx_a};
            wr_max    = q_val;
            wr_min    = q_val;
            rd_addr_a = {LVL_W'(0), q_idx_a - IDX_W'(1)};
          end
          strmm_pkg::OP_QUERY: begin
            rd_addr_a = {q_lvl, q_idx_a};
          end
          default: begin
            load_out = q_pop;
            new_max  = '0;
            new_min  = '0;
            new_bad  = 1'b1;
          end
        endcase
      end
      strmm_pkg::ST_APPEND: begin
        wr_en = 1'b1;
      end
      strmm_pkg::ST_QDATA: begin
        load_out = 1'b1;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // table storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      max_mem[wr_addr] <= wr_max;
      min_mem[wr_addr] <= wr_min;
    end
    rd_a_max <= max_mem[rd_addr_a];
    rd_b_max <= max_mem[rd_addr_b];
    rd_a_min <= min_mem[rd_addr_a];
    rd_b_min <= min_mem[rd_addr_b];
  end

  // level sweep registers
  always_ff @(posedge clk) begin
    if (state == strmm_pkg::ST_IDLE) begin
      cur_max <= q_val;
      cur_min <= q_val;
      j       <= q_idx_a - IDX_W'(1);
      step    <= IDX_W'(2);
      k       <= LVL_W'(1);
      top     <= q_lvl;
    end else if (state == strmm_pkg::ST_APPEND) begin
      cur_max <= app_max;
      cur_min <= app_min;
      j       <= j - step;
      step    <= step << 1;
      k       <= k + LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= strmm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load_out) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.range_max <= new_max;
      res.range_min <= new_min;
      res.bad_range <= new_bad;
    end
  end

endmodule

// ===== hw/rtl/sparse_table_range_min_max_unit.sv =====
// ----------------------------------------------------------------------------
// sparse_table_range_min_max_unit
// Sparse table over a growing signed array, answering range max/min queries.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                                  | result
//   --------+-----+------------------------------------------+------------------
//   req     | in  | req_type, value, range_low, range_high   | query only
//   res     | out | range_max, range_min, bad_range          | one per query
//
// Flow: the front end takes one request a cycle while the command queue
// has room. In the back end an append writes level 0, then sweeps levels
// 1 to L through the table write port, L being the highest table level it
// fills (floor(log2(count+1)), at most LEVELS-1).
// A query does a registered table read, then the compare.
// Clears and unused request codes end in the front end and are not queued.
// Reset: rst clears the element count, queue and sequencer. Table contents
// are not cleared; results only use entries written since the last clear.
// Stalls: a held result leaves appends running; the back end waits with a
// query until the result register is free, and the queue absorbs two
// commands before req.ready drops.
//
module sparse_table_range_min_max_unit #(
  parameter int MAX_ELEMS  = 1024,
  parameter int LEVELS     = 11,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  strmm_req_if.sink   req,
  strmm_res_if.source res
);

  localparam int IDX_W = $clog2(MAX_ELEMS);
  localparam int LVL_W = $clog2(LEVELS);
  localparam int OP_W  = $bits(strmm_pkg::op_t);
  // command word: op, value, two indexes, level
  localparam int CMD_W = OP_W + VALUE_BITS + 2 * IDX_W + LVL_W;

  logic                         f_push;
  logic                         f_ready;
  strmm_pkg::op_t               f_op;
  logic signed [VALUE_BITS-1:0] f_val;
  logic [IDX_W-1:0]             f_idx_a;
  logic [IDX_W-1:0]             f_idx_b;
  logic [LVL_W-1:0]             f_lvl;

  logic [CMD_W-1:0]             push_data;
  logic [CMD_W-1:0]             head;
  logic                         h_valid;
  logic                         h_pop;
  logic [OP_W-1:0]              h_op_bits;
  strmm_pkg::op_t               h_op;
  logic signed [VALUE_BITS-1:0] h_val;
  logic [IDX_W-1:0]             h_idx_a;
  logic [IDX_W-1:0]             h_idx_b;
  logic [LVL_W-1:0]             h_lvl;

  strmm_front #(
    .MAX_ELEMS  (MAX_ELEMS),
    .LEVELS     (LEVELS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push       (f_push),
    .push_ready (f_ready),
    .op         (f_op),
    .val        (f_val),
    .idx_a      (f_idx_a),
    .idx_b      (f_idx_b),
    .lvl        (f_lvl)
  );

  assign push_data = {OP_W'(f_op), f_val, f_idx_a, f_idx_b, f_lvl};

  strmm_queue #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_data  (push_data),
    .push_ready (f_ready),
    .pop        (h_pop),
    .pop_valid  (h_valid),
    .pop_data   (head)
  );

  assign {h_op_bits, h_val, h_idx_a, h_idx_b, h_lvl} = head;
  assign h_op = strmm_pkg::op_t'(h_op_bits);

  strmm_back #(
    .MAX_ELEMS  (MAX_ELEMS),
    .LEVELS     (LEVELS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (h_valid),
    .q_pop   (h_pop),
    .q_op    (h_op),
    .q_val   (h_val),
    .q_idx_a (h_idx_a),
    .q_idx_b (h_idx_b),
    .q_lvl   (h_lvl),
    .res     (res)
  );

endmodule

// ===== hw/rtl/strmm_checker.sv =====
// ----------------------------------------------------------------------------
// strmm_checker
// Port-level checks for the sparse table range min/max unit.
// ----------------------------------------------------------------------------
module strmm_checker #(
  parameter int VALUE_BITS = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [1:0]            in_req_type,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [VALUE_BITS-1:0] out_max,
  input logic [VALUE_BITS-1:0] out_min,
  input logic                  out_bad
);

  logic       q_in;
  logic       r_out;
  logic [3:0] pend;

  assign q_in  = in_valid && in_ready && (in_req_type == strmm_pkg::REQ_QUERY);
  assign r_out = out_valid && out_ready;

  // queries taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 4'(q_in) - 4'(r_out);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_max) && $stable(out_min)
      && $stable(out_bad))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_bad |-> out_max == '0 && out_min == '0)
    else $error("rejected range carries nonzero data");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend != '0)
    else $error("result without an outstanding query");

endmodule

bind sparse_table_range_min_max_unit strmm_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_strmm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .in_req_type (req.req_type),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .out_max     (res.range_max),
  .out_min     (res.range_min),
  .out_bad     (res.bad_range)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives clear, append and range query requests into the sparse table unit
// and checks every range max/min result against a local copy of the tables.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_ELEMS    = 1024;
  localparam int LEVELS       = 11;
  localparam int VALUE_BITS   = 32;
  // Longest append sweep plus margin; used for the pause and the final drain.
  localparam int DRAIN_CYCLES = LEVELS + 8;
  // req_type 3 has no meaning; the unit must drop it silently.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef logic signed [VALUE_BITS-1:0] elem_t;
  typedef logic [strmm_pkg::RNG_W-1:0]  rng_t;

  typedef struct {
    elem_t range_max;
    elem_t range_min;
    logic  bad_range;
  } range_answer_t;

  logic clk = 1'b0;
  logic rst;

  strmm_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
  strmm_res_if #(.VALUE_BITS(VALUE_BITS)) res_ch ();

  sparse_table_range_min_max_unit #(
    .MAX_ELEMS (MAX_ELEMS),
    .LEVELS    (LEVELS),
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Local sparse tables: level k, entry j covers 2^k elements from index j.
  // --------------------------------------------------------------------------
  int unsigned   elem_count;
  elem_t         max_levels [LEVELS][MAX_ELEMS];
  elem_t         min_levels [LEVELS][MAX_ELEMS];
  range_answer_t pending_answers[$];
  int            mismatch_count;

  // Sender burst state; sender_steady turns the gaps off for a stretch.
  int unsigned   burst_left;
  bit            sender_steady;

  function automatic void table_append(input elem_t val);
    int unsigned idx, k, span, half, j;
    // A full array swallows the append.
    if (elem_count >= MAX_ELEMS) return;
    idx = elem_count;
    max_levels[0][idx] = val;
    min_levels[0][idx] = val;
    // Fill each level whose block ends at the new element.
    for (k = 1; k < LEVELS; k++) begin
      span = 1 << k;
      half = span >> 1;
      if (span > idx + 1) break;
      j = idx + 1 - span;
      max_levels[k][j] = (max_levels[k-1][j] < max_levels[k-1][j+half]) ?
                         max_levels[k-1][j+half] : max_levels[k-1][j];
      min_levels[k][j] = (min_levels[k-1][j+half] < min_levels[k-1][j]) ?
                         min_levels[k-1][j+half] : min_levels[k-1][j];
    end
    elem_count = idx + 1;
  endfunction

  function automatic range_answer_t table_query(input rng_t lo, input rng_t hi);
    range_answer_t ans;
    int unsigned   span, lvl, tail;
    ans.range_max = '0;
    ans.range_min = '0;
    ans.bad_range = 1'b1;
    if (elem_count == 0 || lo > hi || hi >= elem_count) return ans;
    span = hi - lo + 1;
    // Largest power of two within the span, capped at the top level.
    lvl = 0;
    while (lvl + 1 < LEVELS && (1 << (lvl + 1)) <= span) lvl++;
    tail = hi + 1 - (1 << lvl);
    ans.range_max = (max_levels[lvl][lo] < max_levels[lvl][tail]) ?
                    max_levels[lvl][tail] : max_levels[lvl][lo];
    ans.range_min = (min_levels[lvl][tail] < min_levels[lvl][lo]) ?
                    min_levels[lvl][tail] : min_levels[lvl][lo];
    ans.bad_range = 1'b0;
    return ans;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: MISMATCH %s", $time, what);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Request side. valid stays high across back-to-back transactions and drops
  // only for a gap or a wait for answers, so each step sees one assignment.
  // --------------------------------------------------------------------------
  task automatic send_req(input logic [1:0] kind, input elem_t val,
                          input rng_t lo, input rng_t hi);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.value      <= val;
    req_ch.range_low  <= lo;
    req_ch.range_high <= hi;
    do @(posedge clk); while (!req_ch.ready);
    // Transaction accepted at this edge: advance the local tables.
    case (kind)
      strmm_pkg::REQ_CLEAR:  elem_count = 0;
      strmm_pkg::REQ_APPEND: table_append(val);
      strmm_pkg::REQ_QUERY:  pending_answers.push_back(table_query(lo, hi));
      default: ;
    endcase
  endtask

  task automatic send_query(input int unsigned lo, input int unsigned hi);
    send_req(strmm_pkg::REQ_QUERY, elem_t'($urandom),
             strmm_pkg::RNG_W'(lo), strmm_pkg::RNG_W'(hi));
  endtask

  task automatic send_append(input elem_t val);
    send_req(strmm_pkg::REQ_APPEND, val,
             strmm_pkg::RNG_W'($urandom), strmm_pkg::RNG_W'($urandom));
  endtask

  // Query whose range lies inside the stored array; needs elem_count > 0.
  task automatic send_good_query();
    int unsigned lo, hi, ext;
    lo  = $urandom_range(0, elem_count - 1);
    ext = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0)
      hi = (lo + ext < elem_count) ? lo + ext : lo;
    else
      hi = $urandom_range(lo, elem_count - 1);
    send_query(lo, hi);
  endtask

  // Holds the sender until every outstanding result is back.
  task automatic wait_for_answers();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Extreme values show up often enough to hit the signed compares.
  function automatic elem_t pick_value();
    case ($urandom_range(0, 11))
      0: return {1'b1, {(VALUE_BITS-1){1'b0}}};
      1: return {1'b0, {(VALUE_BITS-1){1'b1}}};
      2: return '0;
      3: return '1;
      4: return elem_t'($urandom_range(0, 15)) - 8;
      default: return elem_t'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: stall pattern and checker.
  // --------------------------------------------------------------------------
  int unsigned stall_mode, mode_left, hold_left, ready_phase;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      // Modes: always ready, coin flip, long holds, fixed 3-of-4 pattern.
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(50, 300);
    end
    mode_left--;
    ready_phase++;
    case (stall_mode)
      0: res_ch.ready <= 1'b1;
      1: res_ch.ready <= 1'($urandom_range(0, 1));
      2: begin
        if (hold_left == 0) begin
          res_ch.ready <= ~res_ch.ready;
          hold_left = $urandom_range(1, 20);
        end else begin
          hold_left--;
        end
      end
      default: res_ch.ready <= (ready_phase % 4 != 0);
    endcase
  end

  always @(posedge clk) begin
    range_answer_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result max=%0d min=%0d bad=%0b",
                                  res_ch.range_max, res_ch.range_min, res_ch.bad_range));
      end else begin
        want = pending_answers.pop_front();
        if (res_ch.range_max !== want.range_max)
          report_mismatch($sformatf("range_max got %0d want %0d",
                                    res_ch.range_max, want.range_max));
        if (res_ch.range_min !== want.range_min)
          report_mismatch($sformatf("range_min got %0d want %0d",
                                    res_ch.range_min, want.range_min));
        if (res_ch.bad_range !== want.bad_range)
          report_mismatch($sformatf("bad_range got %0b want %0b",
                                    res_ch.bad_range, want.bad_range));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every query on an empty array is rejected.
  task automatic test_empty_array();
    send_query(0, 0);
    send_query(1023, 1023);
    send_query(5, 2);
  endtask

  // Signed extremes, single elements, whole array and the bad range edges.
  task automatic test_edge_values();
    send_append({1'b1, {(VALUE_BITS-1){1'b0}}});
    send_append({1'b0, {(VALUE_BITS-1){1'b1}}});
    send_append('0);
    send_append('1);
    send_append(1);
    send_query(0, 0);
    send_query(1, 1);
    send_query(0, 4);
    send_query(1, 3);
    send_query(0, 1);
    send_query(3, 2);     // low above high
    send_query(0, 5);     // high equals count
    send_query(0, 1023);  // high far past count
    wait_for_answers();
  endtask

  // Code 3 must leave the array untouched and return nothing.
  task automatic test_unused_code();
    send_req(REQ_UNUSED, '1, '1, '1);
    send_query(0, 4);
  endtask

  // After a clear only fresh entries may be read.
  task automatic test_clear();
    send_req(strmm_pkg::REQ_CLEAR, elem_t'($urandom),
             strmm_pkg::RNG_W'($urandom), strmm_pkg::RNG_W'($urandom));
    send_query(0, 0);
    send_append(7);
    send_append(-7);
    send_query(0, 1);
  endtask

  // Fill to capacity, push past it, then query across the whole array.
  task automatic test_full_array();
    send_req(strmm_pkg::REQ_CLEAR, '0, '0, '0);
    repeat (MAX_ELEMS) send_append(pick_value());
    repeat (3) send_append(pick_value());  // ignored, array full
    send_query(0, 1023);
    send_query(1023, 1023);
    send_query(0, 0);
    send_query(512, 1023);
    send_query(1, 1023);
    repeat (80) send_good_query();
    repeat (10) send_query($urandom_range(0, 1023), $urandom_range(0, 1023));
    wait_for_answers();
  endtask

  // Mostly appends and in-range queries on arrays of varied size, with some
  // clears, bad ranges and unused codes mixed in.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned done, pick;
    done = 0;
    while (done < n_items) begin
      if (done % 64 == 0) sender_steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_req(strmm_pkg::REQ_CLEAR, elem_t'($urandom),
                 strmm_pkg::RNG_W'($urandom), strmm_pkg::RNG_W'($urandom));
      end else if (pick < 50) begin
        send_append(pick_value());
      end else if (pick < 85 && elem_count > 0) begin
        send_good_query();
      end else if (pick < 96) begin
        send_query($urandom_range(0, 1023), $urandom_range(0, 1023));
      end else begin
        send_req(REQ_UNUSED, elem_t'($urandom),
                 strmm_pkg::RNG_W'($urandom), strmm_pkg::RNG_W'($urandom));
        continue;  // dropped by the unit, does not count
      end
      done++;
    end
    sender_steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = strmm_pkg::REQ_CLEAR;
    req_ch.value      = '0;
    req_ch.range_low  = '0;
    req_ch.range_high = '0;
    res_ch.ready      = 1'b0;
    elem_count        = 0;
    mismatch_count    = 0;
    burst_left        = 0;
    sender_steady     = 1'b0;
    stall_mode        = 0;
    mode_left         = 0;
    hold_left         = 0;
    ready_phase       = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_array();
    test_edge_values();
    test_unused_code();
    test_clear();
    test_full_array();
    test_random_traffic(470);

    req_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    // Let any stray result show up before the verdict.
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
